[sv/srt_pkg.sv]
// ---------------------------------------------------------------------------
// srt_pkg
// Types, codes and defaults shared by the sorted record table and its cells.
// ---------------------------------------------------------------------------
package srt_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int KEY_W   = 64;
  localparam int ADDR_W  = 64;
  localparam int PHONE_W = 50;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;
  localparam int ACT_W   = 3;
  localparam int SEL_W   = 2;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = 5;

  localparam int IN_DATA_W  = 200;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 208;
  localparam int OUT_USER_W = 3;

  // Actions
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MODIFY = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LIST   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_LISTM  = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADSEL   = 3'd4;

  // Modify selectors
  localparam logic [SEL_W-1:0] SEL_ADDR  = 2'd1;
  localparam logic [SEL_W-1:0] SEL_PHONE = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [ADDR_W-1:0]  addr;
    logic [PHONE_W-1:0] phone;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } rec_t;

  typedef enum logic [2:0] {
    CTL_KEEP,
    CTL_LOAD,
    CTL_FROM_PREV,
    CTL_FROM_NEXT,
    CTL_SET_ADDR,
    CTL_SET_PHONE
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

endpackage

[sv/srt_cell.sv]
// ---------------------------------------------------------------------------
// srt_cell
// One table slot: holds a record, compares its key against the probe key and
// takes a new record, a neighbor's record or a field update on command.
// ---------------------------------------------------------------------------
module srt_cell (
  input  logic                                clk,
  input  srt_pkg::cell_ctl_t                  ctl,
  input  srt_pkg::rec_t                       rec_prev,
  input  srt_pkg::rec_t                       rec_next,
  input  srt_pkg::rec_t                       rec_new,
  input  logic [srt_pkg::KEY_W-1:0]           probe_key,
  output srt_pkg::rec_t                       rec,
  output logic                                key_lt,
  output logic                                key_eq
);

  srt_pkg::rec_t rec_r;
  srt_pkg::rec_t rec_nxt;

  // Compare stored key against the probe
  assign key_lt = rec_r.key < probe_key;
  assign key_eq = rec_r.key == probe_key;
  assign rec    = rec_r;

  // Select next content
  always_comb begin
    rec_nxt = rec_r;
    unique case (ctl)
      srt_pkg::CTL_KEEP:      rec_nxt = rec_r;
      srt_pkg::CTL_LOAD:      rec_nxt = rec_new;
      srt_pkg::CTL_FROM_PREV: rec_nxt = rec_prev;
      srt_pkg::CTL_FROM_NEXT: rec_nxt = rec_next;
      srt_pkg::CTL_SET_ADDR:  rec_nxt.addr = rec_new.addr;
      srt_pkg::CTL_SET_PHONE: rec_nxt.phone = rec_new.phone;
      default:                rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

[sv/sorted_record_table.sv]
// ---------------------------------------------------------------------------
// sorted_record_table
// Key-ordered record table built as a chain of cells that compare in parallel
// and shift one place to open or close a gap.
// ---------------------------------------------------------------------------
// An input transfer is registered, then the cell compare and update run in
// the execute state and the result goes to the output register; a busy
// output holds the action until it is free. List actions report their
// records one by one through the single output register. Input is held
// off while an action runs. Reset empties the table (count to zero).
// ---------------------------------------------------------------------------
module sorted_record_table #(
  parameter int DEPTH = srt_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // key[63:0], address_word[127:64], phone[177:128], birth_day[182:178],
  // birth_month[186:183], birth_year[198:187], zero pad
  input  logic [srt_pkg::IN_DATA_W-1:0]     in_tdata,
  // action[2:0], change_select[4:3]
  input  logic [srt_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // name_key_res[63:0], address_word_res[127:64], phone_res[177:128],
  // birth_day_res[182:178], birth_month_res[186:183],
  // birth_year_res[198:187], entry_count[203:199], zero pad
  output logic [srt_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status[2:0]
  output logic [srt_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tlast
);

  localparam int CW = $clog2(DEPTH + 1);

  srt_pkg::state_t state_r, state_nxt;
  logic [srt_pkg::ACT_W-1:0] act_r;
  logic [srt_pkg::SEL_W-1:0] sel_r;
  srt_pkg::rec_t             in_rec_r;
  logic [CW-1:0]             count_r, count_nxt;
  logic [DEPTH-1:0]          rem_r, rem_nxt;

  logic                       out_valid_r;
  srt_pkg::rec_t              out_rec_r;
  logic [srt_pkg::STAT_W-1:0] out_stat_r;
  logic [srt_pkg::CNT_W-1:0]  out_cnt_r;
  logic                       out_last_r;

  logic                       o_load;
  srt_pkg::rec_t              o_rec;
  logic [srt_pkg::STAT_W-1:0] o_stat;
  logic                       o_last;

  srt_pkg::cell_ctl_t ctl [DEPTH];
  srt_pkg::rec_t      cell_rec [DEPTH];
  logic [DEPTH-1:0]   lt_raw, eq_raw, valid_v, lt_v, hit_v, match_v;
  logic [DEPTH-1:0]   low_bit, pick_v;
  srt_pkg::rec_t      pick_rec;
  logic               found, out_free, in_fire;

  assign in_tready = (state_r == srt_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    srt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[g]),
      .rec_prev  ((g == 0) ? in_rec_r : cell_rec[(g == 0) ? 0 : g - 1]),
      .rec_next  ((g == DEPTH - 1) ? cell_rec[g] :
                  cell_rec[(g == DEPTH - 1) ? g : g + 1]),
      .rec_new   (in_rec_r),
      .probe_key (in_rec_r.key),
      .rec       (cell_rec[g]),
      .key_lt    (lt_raw[g]),
      .key_eq    (eq_raw[g])
    );
  end

  // Occupancy and match flags
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_v[i] = CW'(i) < count_r;
      match_v[i] = valid_v[i] &&
                   ((act_r == srt_pkg::ACT_LIST) || (cell_rec[i].month == in_rec_r.month));
    end
    lt_v  = lt_raw & valid_v;
    hit_v = eq_raw & valid_v;
    found = |hit_v;
  end

  // Pick one record by one-hot select
  assign low_bit = rem_r & (~rem_r + DEPTH'(1));
  assign pick_v  = (state_r == srt_pkg::S_LIST) ? low_bit : hit_v;

  always_comb begin
    pick_rec = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pick_v[i]) pick_rec = pick_rec | cell_rec[i];
    end
  end

  // Sequence the action
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    o_load    = 1'b0;
    o_rec     = '0;
    o_stat    = srt_pkg::ST_OK;
    o_last    = 1'b1;
    for (int i = 0; i < DEPTH; i++) ctl[i] = srt_pkg::CTL_KEEP;

    unique case (state_r)
      srt_pkg::S_IDLE: begin
        if (in_fire) state_nxt = srt_pkg::S_EXEC;
      end
      srt_pkg::S_EXEC: begin
        if (act_r == srt_pkg::ACT_LIST || act_r == srt_pkg::ACT_LISTM) begin
          if (match_v == '0) begin
            if (out_free) begin
              o_load    = 1'b1;
              o_stat    = srt_pkg::ST_NOTFOUND;
              state_nxt = srt_pkg::S_IDLE;
            end
          end else begin
            rem_nxt   = match_v;
            state_nxt = srt_pkg::S_LIST;
          end
        end else if (act_r > srt_pkg::ACT_LISTM) begin
          state_nxt = srt_pkg::S_IDLE;
        end else if (out_free) begin
          o_load    = 1'b1;
          state_nxt = srt_pkg::S_IDLE;
          unique case (act_r)
            srt_pkg::ACT_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                o_stat = srt_pkg::ST_FULL;
              end else if (found) begin
                o_stat = srt_pkg::ST_DUP;
              end else begin
                o_rec     = in_rec_r;
                count_nxt = count_r + CW'(1);
                for (int i = 0; i < DEPTH; i++) begin
                  if (lt_v[i]) ctl[i] = srt_pkg::CTL_KEEP;
                  else if (i == 0) ctl[i] = srt_pkg::CTL_LOAD;
                  else if (lt_v[(i == 0) ? 0 : i - 1]) ctl[i] = srt_pkg::CTL_LOAD;
                  else ctl[i] = srt_pkg::CTL_FROM_PREV;
                end
              end
            end
            srt_pkg::ACT_DELETE: begin
              if (!found) begin
                o_stat = srt_pkg::ST_NOTFOUND;
              end else begin
                o_rec     = pick_rec;
                count_nxt = count_r - CW'(1);
                for (int i = 0; i < DEPTH; i++) begin
                  if (!lt_v[i]) ctl[i] = srt_pkg::CTL_FROM_NEXT;
                end
              end
            end
            srt_pkg::ACT_MODIFY: begin
              if (!found) begin
                o_stat = srt_pkg::ST_NOTFOUND;
              end else begin
                o_rec = pick_rec;
                if (sel_r == srt_pkg::SEL_ADDR) begin
                  o_rec.addr = in_rec_r.addr;
                  for (int i = 0; i < DEPTH; i++)
                    if (hit_v[i]) ctl[i] = srt_pkg::CTL_SET_ADDR;
                end else if (sel_r == srt_pkg::SEL_PHONE) begin
                  o_rec.phone = in_rec_r.phone;
                  for (int i = 0; i < DEPTH; i++)
                    if (hit_v[i]) ctl[i] = srt_pkg::CTL_SET_PHONE;
                end else begin
                  o_stat = srt_pkg::ST_BADSEL;
                end
              end
            end
            default: begin
              if (!found) o_stat = srt_pkg::ST_NOTFOUND;
              else o_rec = pick_rec;
            end
          endcase
        end
      end
      srt_pkg::S_LIST: begin
        if (out_free) begin
          o_load  = 1'b1;
          o_rec   = pick_rec;
          o_last  = (rem_r & ~low_bit) == '0;
          rem_nxt = rem_r & ~low_bit;
          if (o_last) state_nxt = srt_pkg::S_IDLE;
        end
      end
      default: state_nxt = srt_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (o_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Capture input transfer and result payload
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (in_fire) begin
      act_r          <= in_tuser[2:0];
      sel_r          <= in_tuser[4:3];
      in_rec_r.key   <= in_tdata[63:0];
      in_rec_r.addr  <= in_tdata[127:64];
      in_rec_r.phone <= in_tdata[177:128];
      in_rec_r.day   <= in_tdata[182:178];
      in_rec_r.month <= in_tdata[186:183];
      in_rec_r.year  <= in_tdata[198:187];
    end
    if (o_load) begin
      out_rec_r  <= o_rec;
      out_stat_r <= o_stat;
      out_cnt_r  <= srt_pkg::CNT_W'(count_nxt);
      out_last_r <= o_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_cnt_r, out_rec_r.year, out_rec_r.month, out_rec_r.day,
                       out_rec_r.phone, out_rec_r.addr, out_rec_r.key};

endmodule
